// ===== hdl/gsa_pkg.sv =====
// Shared types, sizes and op codes for the generational slot allocator.
package gsa_pkg;

  localparam int SLOTS     = 64;
  localparam int GEN_BITS  = 16;
  localparam int IDX_W     = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_GEN_W = 16;
  localparam int HGEN_W    = 16;
  localparam int SIDX_W    = 8;
  localparam int CMP_W     = 32;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  typedef logic [GEN_BITS-1:0] gen_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [SIDX_W-1:0] slot_index;
    logic [HGEN_W-1:0] handle_generation;
    logic              setup_ok;
  } in_t;

  typedef struct packed {
    logic                 ok;
    logic [OUT_IDX_W-1:0] out_index;
    logic [OUT_GEN_W-1:0] out_generation;
  } out_t;

  typedef struct packed {
    logic any;
    idx_t idx;
  } free_slot_t;

endpackage

// ===== hdl/gsa_gen_mem.sv =====
// Generation store: one write port, one read port, registered read data.
module gsa_gen_mem
  import gsa_pkg::*;
(
  input  logic clk,
  input  logic we,
  input  idx_t waddr,
  input  gen_t wdata,
  input  logic re,
  input  idx_t raddr,
  output gen_t rdata
);

  gen_t mem [SLOTS];
  gen_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/gsa_free_enc.sv =====
// Lowest free slot search: groups of eight, then the first group with a free slot.
module gsa_free_enc
  import gsa_pkg::*;
(
  input  logic [SLOTS-1:0] alive,
  output free_slot_t       free_slot
);

  localparam int GRP  = 8;
  localparam int NGRP = (SLOTS + GRP - 1) / GRP;

  logic [NGRP*GRP-1:0] free_v;
  logic [NGRP-1:0]     grp_any;
  logic [2:0]          grp_pos [NGRP];

  // padding slots read as alive so they are never picked
  always_comb begin
    free_v = '0;
    free_v[SLOTS-1:0] = ~alive;
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |free_v[g*GRP +: GRP];
      grp_pos[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (free_v[g*GRP + b]) begin
          grp_pos[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    free_slot = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        free_slot.any = 1'b1;
        free_slot.idx = IDX_W'(g * GRP) + IDX_W'(grp_pos[g]);
      end
    end
  end

endmodule

// ===== hdl/generational_slot_allocator_top.sv =====
// The result strobe is registered out of the RMW state; start is taken again only in idle.
// Idle reads the slot generation; the RMW state checks it, or bumps and writes it on alloc.
// busy is high only in the read-modify-write cycle; the result register frees the front end.
// Synchronous active-low reset clears all alive bits and marks every generation as zero.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module generational_slot_allocator_top
  import gsa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  typedef enum logic {
    S_IDLE,
    S_RMW
  } state_t;

  state_t           state_r, state_nxt;
  logic             busy_r;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_item_r, out_item_nxt;
  logic [SLOTS-1:0] alive_r, alive_nxt;
  logic [SLOTS-1:0] written_r, written_nxt;

  logic              op_alloc_r;
  logic [1:0]        op_r;
  logic [HGEN_W-1:0] hgen_r;
  logic              setup_r;
  logic              found_r;
  logic              inrange_r;
  idx_t              addr_r;

  free_slot_t free_slot;
  logic       accept;
  idx_t       rd_addr;
  gen_t       rdata;
  gen_t       cur_gen;
  gen_t       inc_gen;
  gen_t       new_gen;
  logic       handle_ok;
  logic       mem_we;

  gsa_free_enc u_free_enc (
    .alive     (alive_r),
    .free_slot (free_slot)
  );

  assign accept  = start && !busy_r;
  assign rd_addr = (in_item.op == OP_ALLOC) ? free_slot.idx : in_item.slot_index[IDX_W-1:0];

  gsa_gen_mem u_gen_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_r),
    .wdata (new_gen),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // slots not written since reset read as generation zero
  assign cur_gen = written_r[addr_r] ? rdata : '0;
  assign inc_gen = cur_gen + gen_t'(1);
  assign new_gen = (inc_gen == '0) ? gen_t'(1) : inc_gen;

  assign handle_ok = (hgen_r != '0) && inrange_r && alive_r[addr_r] &&
                     (CMP_W'(cur_gen) == CMP_W'(hgen_r));

  assign mem_we = (state_r == S_RMW) && op_alloc_r && found_r && setup_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    alive_nxt     = alive_r;
    written_nxt   = written_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RMW;
        end
      end
      S_RMW: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '0;
        case (op_r)
          OP_ALLOC: begin
            if (found_r && setup_r) begin
              alive_nxt[addr_r]           = 1'b1;
              written_nxt[addr_r]         = 1'b1;
              out_item_nxt.ok             = 1'b1;
              out_item_nxt.out_index      = OUT_IDX_W'(addr_r);
              out_item_nxt.out_generation = OUT_GEN_W'(new_gen);
            end
          end
          OP_CHECK: begin
            out_item_nxt.ok = handle_ok;
          end
          OP_FREE: begin
            if (handle_ok) begin
              alive_nxt[addr_r] = 1'b0;
              out_item_nxt.ok   = 1'b1;
            end
          end
          default: begin
            out_item_nxt.ok = 1'b0;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt == S_RMW);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r   <= '0;
      written_r <= '0;
    end else begin
      alive_r   <= alive_nxt;
      written_r <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (accept) begin
      op_r       <= in_item.op;
      op_alloc_r <= (in_item.op == OP_ALLOC);
      hgen_r     <= in_item.handle_generation;
      setup_r    <= in_item.setup_ok;
      found_r    <= free_slot.any;
      inrange_r  <= ({1'b0, in_item.slot_index} < (SIDX_W + 1)'(SLOTS));
      addr_r     <= rd_addr;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sim/generational_slot_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the generational slot allocator top level.
module generational_slot_allocator_top_tb;
  import gsa_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 700;

  // Tracks the pool as the block should see it and queues the reply for each item.
  class slot_pool_tracker;
    bit   alive [SLOTS];
    gen_t slot_gen [SLOTS];
    out_t pending_replies [$];
    int   errors, replies, alloc_ok, frees_ok, checks_ok, pool_full, wraps;

    function new();
      foreach (alive[i]) begin
        alive[i]    = 1'b0;
        slot_gen[i] = '0;
      end
    endfunction

    function bit handle_ok(in_t it);
      int idx;
      idx = int'(it.slot_index);
      if (it.handle_generation == '0) return 1'b0;
      if (idx >= SLOTS) return 1'b0;
      if (!alive[idx]) return 1'b0;
      return CMP_W'(slot_gen[idx]) == CMP_W'(it.handle_generation);
    endfunction

    function void note_request(in_t it);
      out_t reply;
      int   lowest;
      gen_t next_gen;
      reply  = '0;
      lowest = -1;
      case (it.op)
        OP_ALLOC: begin
          for (int i = SLOTS - 1; i >= 0; i--) if (!alive[i]) lowest = i;
          if (lowest < 0) begin
            pool_full++;
          end else if (it.setup_ok) begin
            next_gen = slot_gen[lowest] + 1'b1;
            // generation zero is reserved for invalid handles
            if (next_gen == '0) begin
              next_gen = gen_t'(1);
              wraps++;
            end
            slot_gen[lowest]     = next_gen;
            alive[lowest]        = 1'b1;
            reply.ok             = 1'b1;
            reply.out_index      = OUT_IDX_W'(lowest);
            reply.out_generation = OUT_GEN_W'(next_gen);
            alloc_ok++;
          end
        end
        OP_CHECK: begin
          reply.ok = handle_ok(it);
          if (reply.ok) checks_ok++;
        end
        OP_FREE: begin
          if (handle_ok(it)) begin
            alive[int'(it.slot_index)] = 1'b0;
            reply.ok = 1'b1;
            frees_ok++;
          end
        end
        default: begin
        end
      endcase
      pending_replies.push_back(reply);
    endfunction

    function void check_reply(out_t got);
      out_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: ok=%0d out_index=%0d out_generation=%0d",
               got.ok, got.out_index, got.out_generation);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      replies++;
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        errors++;
      end
      if (got.out_index !== want.out_index) begin
        $error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
        errors++;
      end
      if (got.out_generation !== want.out_generation) begin
        $error("out_generation: expected %0d, got %0d", want.out_generation,
               got.out_generation);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_valid;
  out_t out_item;
  int   stall_cycles = 0;
  bit   idle_on = 1'b1;
  slot_pool_tracker pool = new();

  generational_slot_allocator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) pool.check_reply(out_item);
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("generational_slot_allocator_top_tb: FAIL");
    $finish;
  end

  function automatic in_t req(logic [1:0] op, int idx, int hgen, int setup);
    in_t it;
    it.op                = op;
    it.slot_index        = SIDX_W'(idx);
    it.handle_generation = HGEN_W'(hgen);
    it.setup_ok          = setup[0];
    return it;
  endfunction

  // Holds the item until the edge that takes it, then logs it.
  task automatic send(in_t it);
    if (idle_on && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pool.note_request(it);
  endtask

  task automatic wait_for_replies();
    start <= 1'b0;
    do @(posedge clk); while (pool.pending_replies.size() != 0);
  endtask

  // Grow phases mostly allocate so the pool fills; shrink phases mostly free.
  function automatic in_t pick_random(bit grow);
    int         live [$];
    int         idx, roll;
    logic [1:0] hop;
    for (int i = 0; i < SLOTS; i++) if (pool.alive[i]) live.push_back(i);
    roll = $urandom_range(0, 99);
    if (grow ? roll < 75 : roll < 10)
      return req(OP_ALLOC, $urandom_range(0, 255), $urandom,
                 int'($urandom_range(0, 99) < 85));
    roll = $urandom_range(0, 99);
    if (live.size() != 0 && roll < 75) begin
      idx = live[$urandom_range(0, live.size() - 1)];
      hop = ($urandom_range(0, 99) < (grow ? 40 : 75)) ? OP_FREE : OP_CHECK;
      return req(hop, idx, int'(pool.slot_gen[idx]), $urandom_range(0, 1));
    end
    hop = $urandom_range(0, 1) ? OP_FREE : OP_CHECK;
    idx = $urandom_range(0, SLOTS - 1);
    case ($urandom_range(0, 5))
      0: return req(hop, idx, int'(pool.slot_gen[idx]) ^ $urandom_range(1, 65535),
                    $urandom_range(0, 1));
      1: return req(hop, idx, int'(pool.slot_gen[idx]), $urandom_range(0, 1));
      2: return req(hop, idx, 0, $urandom_range(0, 1));
      3: return req(hop, $urandom_range(SLOTS, 255), $urandom, $urandom_range(0, 1));
      4: return req(OP_UNUSED, $urandom_range(0, 255), $urandom, $urandom_range(0, 1));
      default: return in_t'($urandom);
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send(req(OP_CHECK, 0, 1, 0));          // nothing alive yet
    send(req(OP_ALLOC, 0, 0, 0));          // set-up failed, no bump
    send(req(OP_ALLOC, 255, 65535, 1));    // slot 0, generation 1
    send(req(OP_CHECK, 0, 1, 0));
    send(req(OP_CHECK, 0, 0, 1));          // zero generation
    send(req(OP_CHECK, 0, 2, 0));
    send(req(OP_CHECK, 64, 1, 0));         // index past the pool
    send(req(OP_CHECK, 255, 65535, 1));
    send(req(OP_FREE, 64, 1, 0));
    send(req(OP_FREE, 0, 0, 0));
    send(req(OP_ALLOC, 0, 0, 1));          // slot 1
    send(req(OP_FREE, 0, 1, 1));
    send(req(OP_FREE, 0, 1, 0));           // double free
    send(req(OP_CHECK, 0, 1, 0));
    send(req(OP_CHECK, 1, 1, 0));
    send(req(OP_UNUSED, 255, 65535, 1));
    send(req(OP_ALLOC, 0, 0, 1));          // slot 0 again, generation 2
    send(req(OP_FREE, 0, 2, 0));
    send(req(OP_FREE, 1, 1, 0));
    wait_for_replies();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 250 && n < 400);
      if (n % 150 == 149) wait_for_replies();
      send(pick_random((n / 120) % 2 == 0));
    end

    wait_for_replies();
    repeat (8) @(posedge clk);
    $display("checked %0d replies: %0d allocations, %0d frees, %0d valid checks",
             pool.replies, pool.alloc_ok, pool.frees_ok, pool.checks_ok);
    $display("allocations refused on a full pool: %0d, generation wraps: %0d",
             pool.pool_full, pool.wraps);
    if (pool.errors == 0) begin
      $display("generational_slot_allocator_top_tb: PASS");
    end else begin
      $display("generational_slot_allocator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
